>>> design/sca_pkg.sv
// ----------------------------------------------------------------------------
// Scancode-to-ASCII package
// Shared constants, opcode and state types, and the set-1 US-layout tables.
// ----------------------------------------------------------------------------
package sca_pkg;

   localparam int FIFO_DEPTH_DEFAULT = 256;

   localparam logic [7:0] MAKE_SHIFT  = 8'h2A;
   localparam logic [7:0] BREAK_SHIFT = 8'hAA;

   typedef enum logic {
      OP_SCAN = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // Only the lower 64 codes translate; codes with bit 6 set give zero.
   localparam logic [7:0] PLAIN_MAP [64] = '{
      8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h00, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam logic [7:0] SHIFTED_MAP [64] = '{
      8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   function automatic logic [7:0] translate(input logic shifted, input logic [6:0] code);
      logic [7:0] ch;
      if (code[6]) begin
         ch = 8'h00;
      end else if (shifted) begin
         ch = SHIFTED_MAP[code[5:0]];
      end else begin
         ch = PLAIN_MAP[code[5:0]];
      end
      return ch;
   endfunction

endpackage

>>> design/sca_channels.sv
// ----------------------------------------------------------------------------
// Scancode-to-ASCII channels
// Valid/ready interfaces for the request and response beats.
// ----------------------------------------------------------------------------
interface sca_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] scancode;

   modport source (output valid, output opcode, output scancode, input ready);
   modport sink   (input valid, input opcode, input scancode, output ready);
endinterface

interface sca_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_char;
   logic       char_valid;
   logic       fifo_not_empty;
   logic       char_dropped;

   modport source (output valid, output read_char, output char_valid,
                   output fifo_not_empty, output char_dropped, input ready);
   modport sink   (input valid, input read_char, input char_valid,
                   input fifo_not_empty, input char_dropped, output ready);
endinterface

>>> design/sca_store.sv
// ----------------------------------------------------------------------------
// Character store
// Single-port-write, registered-read memory holding the FIFO characters.
// ----------------------------------------------------------------------------
module sca_store #(
   parameter int DEPTH = sca_pkg::FIFO_DEPTH_DEFAULT,
   parameter int PTR_W = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [PTR_W-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic [PTR_W-1:0] rd_addr,
   output logic [7:0]       rd_data
);
   import sca_pkg::*;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/scancode_to_ascii_fifo_unit.sv
// ----------------------------------------------------------------------------
// Scancode-to-ASCII FIFO unit
// Translates set-1 scancodes to ASCII and queues them in a ring FIFO.
// ----------------------------------------------------------------------------
// Flow: an accepted request is registered and the unit enters the execute
// state, where it waits until the response slot is free; the response beat is
// then registered. No new request is accepted until the execute state ends,
// and the execute state uses the registered read of the character store.
// Reset is synchronous and clears the state machine, the shift flag, both
// pointers and the response valid flag; the character store is not cleared.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo_unit #(
   parameter int FIFO_DEPTH = sca_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   sca_req_if.sink   req,
   sca_rsp_if.source rsp
);
   import sca_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   // The pointer wraps at the depth, which need not be a power of two.
   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] q;
      if (p == PTR_W'(FIFO_DEPTH - 1)) begin
         q = '0;
      end else begin
         q = p + 1'b1;
      end
      return q;
   endfunction

   // Control state.
   state_type        state_ff, state_in;
   logic             shift_ff, shift_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;

   // The accepted request, held through the execute state.
   op_type           op_ff;
   logic [7:0]       code_ff;

   // Response register; it parts the core from a stalled consumer.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       read_char_ff, read_char_in;
   logic             char_valid_ff, char_valid_in;
   logic             not_empty_ff, not_empty_in;
   logic             dropped_ff, dropped_in;

   // Store port.
   logic             wr_en;
   logic [7:0]       wr_data;
   logic [7:0]       rd_data;

   // Execute-cycle decode.
   logic             slot_free;
   logic             fire;
   logic             is_empty;
   logic             is_full;
   logic [7:0]       ch;
   logic             push_try;
   logic             pop;
   logic             push;
   logic             accept;

   sca_store #(
      .DEPTH (FIFO_DEPTH),
      .PTR_W (PTR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // The response slot can take a result when it is empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign fire      = (state_ff == ST_EXEC) && slot_free;

   // Pointers only move on an execute cycle, and the next request is accepted on
   // a later edge, so the registered read at the read pointer always sees any
   // earlier write to that entry without forwarding.
   assign is_empty = (wr_ptr_ff == rd_ptr_ff);
   assign is_full  = (advance(wr_ptr_ff) == rd_ptr_ff);
   assign ch       = translate(shift_ff, code_ff[6:0]);

   // Shift make and break codes never translate, and codes with bit 7 set are
   // ignored; a zero table entry pushes nothing.
   assign push_try = (op_ff == OP_SCAN) && !code_ff[7] && (code_ff != MAKE_SHIFT)
                     && (ch != 8'h00);
   assign pop      = (op_ff == OP_READ) && !is_empty;
   assign push     = push_try && !is_full;

   assign wr_en   = fire && push;
   assign wr_data = ch;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      req.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
         end
         ST_EXEC: begin
            req.ready = 1'b0;
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   // Datapath updates for the execute cycle.
   always_comb begin
      shift_in      = shift_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      read_char_in  = read_char_ff;
      char_valid_in = char_valid_ff;
      not_empty_in  = not_empty_ff;
      dropped_in    = dropped_ff;
      if (fire) begin
         if (op_ff == OP_SCAN) begin
            if (code_ff == MAKE_SHIFT) begin
               shift_in = 1'b1;
            end else if (code_ff == BREAK_SHIFT) begin
               shift_in = 1'b0;
            end
         end
         if (push) begin
            wr_ptr_in = advance(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_in = advance(rd_ptr_ff);
         end
         rsp_valid_in  = 1'b1;
         read_char_in  = pop ? rd_data : 8'h00;
         char_valid_in = pop;
         not_empty_in  = (wr_ptr_in != rd_ptr_in);
         dropped_in    = push_try && is_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shift_ff     <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shift_ff     <= shift_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req.opcode);
         code_ff <= req.scancode;
      end
      read_char_ff  <= read_char_in;
      char_valid_ff <= char_valid_in;
      not_empty_ff  <= not_empty_in;
      dropped_ff    <= dropped_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.read_char      = read_char_ff;
   assign rsp.char_valid     = char_valid_ff;
   assign rsp.fifo_not_empty = not_empty_ff;
   assign rsp.char_dropped   = dropped_ff;

endmodule

>>> design/sca_checker.sv
// ----------------------------------------------------------------------------
// Scancode-to-ASCII checker
// Port-level properties of the unit, bound to the unit module.
// ----------------------------------------------------------------------------
module sca_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_char,
   input logic       rsp_char_valid,
   input logic       rsp_char_dropped
);
   import sca_pkg::*;

   // Queued characters are never zero, so a popped one is nonzero.
   a_pop_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_valid |-> rsp_read_char != 8'h00)
      else $error("popped character is zero");

   // Without a pop the character field reads zero.
   a_nopop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_read_char == 8'h00)
      else $error("character present without a pop");

   // A beat is either a read or a scancode, never both a pop and a drop.
   a_pop_drop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_char_valid && rsp_char_dropped))
      else $error("pop and drop in one beat");

   // One request at a time: the unit is busy the cycle after accepting.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A stalled response beat holds its character.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_char))
      else $error("stalled response changed");

endmodule

bind scancode_to_ascii_fifo_unit sca_checker u_sca_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_read_char    (rsp.read_char),
   .rsp_char_valid   (rsp.char_valid),
   .rsp_char_dropped (rsp.char_dropped)
);
